>>> rtl/style_text_tokenizer_macros.svh
// Assertion helpers used by the tokenizer top level.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef STYLE_TEXT_TOKENIZER_MACROS_SVH
`define STYLE_TEXT_TOKENIZER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define STT_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Check that cons holds in the cycle after ante.
`define STT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

>>> rtl/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    localparam int CHAR_W   = 8;
    localparam int WLEN_W   = 8;
    localparam int RES_MAX  = 3;
    localparam int RCNT_W   = 2;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_WORD    = 3'd1,
        MODE_LINE    = 3'd2,
        MODE_BLOCK   = 3'd3,
        MODE_OPEN    = 3'd4,
        MODE_CLOSE   = 3'd5
    } scan_mode_t;

    typedef enum logic [2:0] {
        KIND_BYTE   = 3'd0,
        KIND_WEND   = 3'd1,
        KIND_LBRACE = 3'd2,
        KIND_RBRACE = 3'd3,
        KIND_COLON  = 3'd4,
        KIND_SEMI   = 3'd5,
        KIND_END    = 3'd6
    } tok_kind_t;

    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

    // Results caused by one item, oldest in slot 0
    typedef struct packed {
        logic [RCNT_W-1:0]                 count;
        tok_kind_t [RES_MAX-1:0]           kind;
        logic [RES_MAX-1:0][CHAR_W-1:0]    chr;
    } res_bundle_t;

    // Append one result to a bundle; a full bundle is left as it is
    function automatic res_bundle_t put_res(res_bundle_t b, tok_kind_t k,
                                            logic [CHAR_W-1:0] ch);
        res_bundle_t r;
        r = b;
        case (b.count)
            2'd0:
            begin
                r.kind[0] = k;
                r.chr[0]  = ch;
                r.count   = 2'd1;
            end
            2'd1:
            begin
                r.kind[1] = k;
                r.chr[1]  = ch;
                r.count   = 2'd2;
            end
            2'd2:
            begin
                r.kind[2] = k;
                r.chr[2]  = ch;
                r.count   = 2'd3;
            end
            default:
            begin
                r = b;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/stt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_front #(
    parameter int MAX_WORD_LEN = 255
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [stt_pkg::CHAR_W-1:0]    text_byte,
    input  wire logic                          end_of_text,
    output stt_pkg::res_bundle_t               bundle,
    output logic                               bundle_valid
);

    logic [stt_pkg::CHAR_W-1:0] pend_char_reg, pend_char_next;
    logic                       pend_valid_reg, pend_valid_next;
    stt_pkg::scan_mode_t        mode_reg, mode_next;
    logic [stt_pkg::WLEN_W-1:0] wlen_reg, wlen_next;

    logic                       text_end;
    logic [stt_pkg::CHAR_W-1:0] c, n;
    logic                       c_space, c_struct, c_room, delim;
    logic                       in_word_cont, wend_pre, go_between;
    logic                       cmt_line, cmt_block, emit_struct, starts_word;
    stt_pkg::tok_kind_t         c_kind;
    stt_pkg::scan_mode_t        proc_mode;
    logic [stt_pkg::WLEN_W-1:0] proc_wlen;

    function automatic logic is_hex(logic [stt_pkg::CHAR_W-1:0] ch);
        return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h66) ||
               (ch >= 8'h41 && ch <= 8'h46);
    endfunction

    // Classify the pending byte against its lookahead
    always_comb
    begin
        text_end = end_of_text || (text_byte == stt_pkg::CH_NUL);
        c        = pend_char_reg;
        n        = text_end ? stt_pkg::CH_NUL : text_byte;
        c_space  = (c == stt_pkg::CH_SPACE) || (c == stt_pkg::CH_TAB) ||
                   (c == stt_pkg::CH_LF) || (c == stt_pkg::CH_CR);
        c_struct = 1'b1;
        case (c)
            stt_pkg::CH_LBRACE: c_kind = stt_pkg::KIND_LBRACE;
            stt_pkg::CH_RBRACE: c_kind = stt_pkg::KIND_RBRACE;
            stt_pkg::CH_COLON:  c_kind = stt_pkg::KIND_COLON;
            stt_pkg::CH_SEMI:   c_kind = stt_pkg::KIND_SEMI;
            default:
            begin
                c_kind   = stt_pkg::KIND_BYTE;
                c_struct = 1'b0;
            end
        endcase
        c_room   = wlen_reg < stt_pkg::WLEN_W'(MAX_WORD_LEN);
        delim    = c_space || c_struct ||
                   (c == stt_pkg::CH_SLASH &&
                    (n == stt_pkg::CH_SLASH || n == stt_pkg::CH_STAR));

        in_word_cont = pend_valid_reg && mode_reg == stt_pkg::MODE_WORD && !delim;
        wend_pre     = pend_valid_reg && mode_reg == stt_pkg::MODE_WORD && delim;
        go_between   = pend_valid_reg && (wend_pre || !(mode_reg inside {
                           stt_pkg::MODE_WORD, stt_pkg::MODE_LINE, stt_pkg::MODE_BLOCK,
                           stt_pkg::MODE_OPEN, stt_pkg::MODE_CLOSE}));
        cmt_line     = go_between && !c_space &&
                       ((c == stt_pkg::CH_SLASH && n == stt_pkg::CH_SLASH) ||
                        (c == stt_pkg::CH_HASH && !is_hex(n)));
        cmt_block    = go_between && c == stt_pkg::CH_SLASH && n == stt_pkg::CH_STAR;
        emit_struct  = go_between && c_struct;
        starts_word  = go_between && !c_space && !cmt_line && !cmt_block && !c_struct;

        // Mode and word length after the pending byte
        proc_mode = mode_reg;
        if (go_between)
        begin
            if (cmt_line)
                proc_mode = stt_pkg::MODE_LINE;
            else if (cmt_block)
                proc_mode = stt_pkg::MODE_OPEN;
            else if (starts_word)
                proc_mode = stt_pkg::MODE_WORD;
            else
                proc_mode = stt_pkg::MODE_BETWEEN;
        end
        else if (pend_valid_reg)
        begin
            case (mode_reg)
                stt_pkg::MODE_OPEN:  proc_mode = stt_pkg::MODE_BLOCK;
                stt_pkg::MODE_CLOSE: proc_mode = stt_pkg::MODE_BETWEEN;
                stt_pkg::MODE_LINE:
                    proc_mode = (c == stt_pkg::CH_LF) ? stt_pkg::MODE_BETWEEN
                                                     : stt_pkg::MODE_LINE;
                stt_pkg::MODE_BLOCK:
                    proc_mode = (c == stt_pkg::CH_STAR && n == stt_pkg::CH_SLASH)
                                ? stt_pkg::MODE_CLOSE : stt_pkg::MODE_BLOCK;
                default:             proc_mode = mode_reg;
            endcase
        end

        if (starts_word)
            proc_wlen = stt_pkg::WLEN_W'(1);
        else if (wend_pre)
            proc_wlen = '0;
        else if (in_word_cont && c_room)
            proc_wlen = wlen_reg + stt_pkg::WLEN_W'(1);
        else
            proc_wlen = wlen_reg;
    end

    // Next state: hold the new byte as lookahead, or clear all at end of text
    always_comb
    begin
        if (text_end)
        begin
            pend_char_next  = '0;
            pend_valid_next = 1'b0;
            mode_next       = stt_pkg::MODE_BETWEEN;
            wlen_next       = '0;
        end
        else
        begin
            pend_char_next  = text_byte;
            pend_valid_next = 1'b1;
            mode_next       = proc_mode;
            wlen_next       = proc_wlen;
        end
    end

    // Results of this item
    always_comb
    begin
        bundle = '0;
        if (in_word_cont && c_room)
            bundle = stt_pkg::put_res(bundle, stt_pkg::KIND_BYTE, c);
        if (wend_pre)
            bundle = stt_pkg::put_res(bundle, stt_pkg::KIND_WEND, stt_pkg::CH_NUL);
        if (emit_struct)
            bundle = stt_pkg::put_res(bundle, c_kind, stt_pkg::CH_NUL);
        if (starts_word)
            bundle = stt_pkg::put_res(bundle, stt_pkg::KIND_BYTE, c);
        if (text_end)
        begin
            if (proc_mode == stt_pkg::MODE_WORD)
                bundle = stt_pkg::put_res(bundle, stt_pkg::KIND_WEND, stt_pkg::CH_NUL);
            bundle = stt_pkg::put_res(bundle, stt_pkg::KIND_END, stt_pkg::CH_NUL);
        end
        bundle_valid = accept && (bundle.count != '0);
    end

    // Advance scan state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_char_reg  <= '0;
            pend_valid_reg <= 1'b0;
            mode_reg       <= stt_pkg::MODE_BETWEEN;
            wlen_reg       <= '0;
        end
        else if (accept)
        begin
            pend_char_reg  <= pend_char_next;
            pend_valid_reg <= pend_valid_next;
            mode_reg       <= mode_next;
            wlen_reg       <= wlen_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/stt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire stt_pkg::res_bundle_t wr_data,
    input  wire logic            rd_en,
    output stt_pkg::res_bundle_t rd_data,
    output logic                 q_full,
    output logic                 q_empty
);

    stt_pkg::res_bundle_t          entry_reg [stt_pkg::QDEPTH];
    logic [stt_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [stt_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == stt_pkg::QCNT_W'(stt_pkg::QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + stt_pkg::QCNT_W'(1);
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - stt_pkg::QCNT_W'(1);
    end

    // Store bundles
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + stt_pkg::QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + stt_pkg::QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/stt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire stt_pkg::res_bundle_t        q_data,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [2:0]                       token_kind,
    output logic [stt_pkg::CHAR_W-1:0]       word_byte,
    output logic                             last_of_run
);

    stt_pkg::res_bundle_t        cur_reg;
    logic                        cur_valid_reg;
    logic [stt_pkg::RCNT_W-1:0]  idx_reg;
    logic                        is_last, take;

    assign empty   = !cur_valid_reg;
    assign is_last = (idx_reg == cur_reg.count - stt_pkg::RCNT_W'(1));
    assign take    = cur_valid_reg && pop;
    assign q_pop   = !q_empty && (!cur_valid_reg || (take && is_last));

    // Select the current result of the held bundle
    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                token_kind = cur_reg.kind[0];
                word_byte  = cur_reg.chr[0];
            end
            2'd1:
            begin
                token_kind = cur_reg.kind[1];
                word_byte  = cur_reg.chr[1];
            end
            default:
            begin
                token_kind = cur_reg.kind[2];
                word_byte  = cur_reg.chr[2];
            end
        endcase
        last_of_run = is_last;
    end

    // Load the next bundle or step through the held one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (q_pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (take)
        begin
            if (is_last)
                cur_valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + stt_pkg::RCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
    end

endmodule

`default_nettype wire

>>> rtl/style_text_tokenizer.sv
// Channel   Direction  Handshake        Payload
// text in   input      push / full      text_byte, end_of_text
// tokens    output     pop / empty      token_kind, word_byte, last_of_run
//
// One text item is accepted per cycle while the bundle queue has room.
// Each item causes zero to three results; results leave one per cycle while pop
// is held, so the output port sets the rate when items produce more than one result.
// An item's results pass through the bundle queue and the output stage register.
// Reset clears the scan state, the queue and the output stage at once.
// Stalls on pop fill the two-entry bundle queue, then raise full.
`timescale 1ns / 1ps
`default_nettype none
`include "style_text_tokenizer_macros.svh"

module style_text_tokenizer #(
    parameter int MAX_WORD_LEN = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  text_byte,
    input  wire logic        end_of_text,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       token_kind,
    output logic [7:0]       word_byte,
    output logic             last_of_run
);

    logic                 accept;
    stt_pkg::res_bundle_t f_bundle, q_data;
    logic                 f_valid, q_full, q_empty, q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Classify bytes and build result bundles
    stt_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .bundle       (f_bundle),
        .bundle_valid (f_valid)
    );

    // Decouple front and back
    stt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid),
        .wr_data (f_bundle),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // Serialize bundles onto the result port
    stt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_data),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .token_kind  (token_kind),
        .word_byte   (word_byte),
        .last_of_run (last_of_run)
    );

    `STT_ASSERT_SAME(a_end_is_last, !empty && !last_of_run, token_kind != stt_pkg::KIND_END)
    `STT_ASSERT_NEXT(a_queue_drains, empty && !q_empty, !empty)
    `STT_ASSERT_NEXT(a_run_continues, pop && !empty && !last_of_run, !empty)

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import stt_pkg::*;

    localparam int WORD_LIMIT   = 255;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 80;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    typedef struct {
        tok_kind_t  kind;
        logic [7:0] chr;
        logic       last;
    } token_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] text_byte = 8'h00;
    logic       end_of_text = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [2:0] token_kind;
    logic [7:0] word_byte;
    logic       last_of_run;

    // Stimulus and scoreboard storage
    text_item_t pending_items[$];
    token_t     expected_tokens[$];
    token_t     run_tokens[$];
    token_t     want_tok;
    int         items_added = 0;
    int         error_count = 0;
    int         cycle_count = 0;
    logic       item_accepted = 1'b0;

    // Idling and hold-off controls
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // Scanner copy used for prediction
    scan_mode_t lex_mode = MODE_BETWEEN;
    logic [7:0] held_char = 8'h00;
    logic       held_valid = 1'b0;
    logic [7:0] word_count = 8'h00;

    style_text_tokenizer #(
        .MAX_WORD_LEN(WORD_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .text_byte(text_byte),
        .end_of_text(end_of_text),
        .empty(empty),
        .pop(pop),
        .token_kind(token_kind),
        .word_byte(word_byte),
        .last_of_run(last_of_run)
    );

    // Clock and reset
    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit is_hex_digit(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_punct(input logic [7:0] c);
        return c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON || c == CH_SEMI;
    endfunction

    function automatic tok_kind_t punct_kind(input logic [7:0] c);
        if (c == CH_LBRACE)
            return KIND_LBRACE;
        if (c == CH_RBRACE)
            return KIND_RBRACE;
        if (c == CH_COLON)
            return KIND_COLON;
        return KIND_SEMI;
    endfunction

    // Append one token to this item's run; at most three fit
    task emit_token(input tok_kind_t kind, input logic [7:0] chr);
        token_t t;
        t.kind = kind;
        t.chr  = chr;
        t.last = 1'b0;
        if (run_tokens.size() < RES_MAX)
            run_tokens.push_back(t);
    endtask

    // Emit a word byte unless the word is already at its limit
    task take_word_byte(input logic [7:0] c);
        if (word_count < WORD_LIMIT)
        begin
            emit_token(KIND_BYTE, c);
            word_count = word_count + 8'd1;
        end
    endtask

    // Decide what the held byte means given the byte after it
    task interpret_char(input logic [7:0] c, input logic [7:0] nx);
        bit ends_word;
        if (lex_mode == MODE_OPEN)
        begin
            lex_mode = MODE_BLOCK;
            return;
        end
        if (lex_mode == MODE_CLOSE)
        begin
            lex_mode = MODE_BETWEEN;
            return;
        end
        if (lex_mode == MODE_LINE)
        begin
            if (c == CH_LF)
                lex_mode = MODE_BETWEEN;
            return;
        end
        if (lex_mode == MODE_BLOCK)
        begin
            if (c == CH_STAR && nx == CH_SLASH)
                lex_mode = MODE_CLOSE;
            return;
        end
        if (lex_mode == MODE_WORD)
        begin
            ends_word = is_blank(c) || is_punct(c) ||
                        (c == CH_SLASH && (nx == CH_SLASH || nx == CH_STAR));
            if (!ends_word)
            begin
                take_word_byte(c);
                return;
            end
            emit_token(KIND_WEND, CH_NUL);
            word_count = 8'h00;
        end
        // between tokens
        lex_mode = MODE_BETWEEN;
        if (is_blank(c))
            return;
        if (c == CH_SLASH && nx == CH_SLASH)
        begin
            lex_mode = MODE_LINE;
            return;
        end
        if (c == CH_SLASH && nx == CH_STAR)
        begin
            lex_mode = MODE_OPEN;
            return;
        end
        if (c == CH_HASH && !is_hex_digit(nx))
        begin
            lex_mode = MODE_LINE;
            return;
        end
        if (is_punct(c))
        begin
            emit_token(punct_kind(c), CH_NUL);
            return;
        end
        lex_mode = MODE_WORD;
        word_count = 8'h00;
        take_word_byte(c);
    endtask

    // Work out the tokens one accepted item causes and queue them
    task predict_tokens(input logic [7:0] c, input logic eot);
        int n;
        run_tokens.delete();
        if (eot || c == CH_NUL)
        begin
            if (held_valid)
                interpret_char(held_char, CH_NUL);
            if (lex_mode == MODE_WORD)
                emit_token(KIND_WEND, CH_NUL);
            emit_token(KIND_END, CH_NUL);
            lex_mode   = MODE_BETWEEN;
            held_char  = 8'h00;
            held_valid = 1'b0;
            word_count = 8'h00;
        end
        else
        begin
            if (held_valid)
                interpret_char(held_char, c);
            held_char  = c;
            held_valid = 1'b1;
        end
        n = run_tokens.size();
        if (n > 0)
            run_tokens[n-1].last = 1'b1;
        foreach (run_tokens[k])
            expected_tokens.push_back(run_tokens[k]);
    endtask

    // ---------------------------------------------------------------- driver

    // Predict each item at the edge that takes it
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            predict_tokens(text_byte, end_of_text);
            item_accepted <= 1'b1;
        end
        else
        begin
            item_accepted <= 1'b0;
        end
    end

    // Drop the taken item and offer the next one, idling at random
    always @(negedge clk)
    begin
        if (item_accepted)
            void'(pending_items.pop_front());
        if (rst_n && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            push        <= 1'b1;
            text_byte   <= pending_items[0].ch;
            end_of_text <= pending_items[0].eot;
        end
        else
        begin
            push <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- monitor

    task report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // Compare each accepted token with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_tokens.size() == 0)
            begin
                report_mismatch("unexpected token, kind", token_kind, -1);
            end
            else
            begin
                want_tok = expected_tokens.pop_front();
                if (token_kind !== want_tok.kind)
                    report_mismatch("token_kind", token_kind, want_tok.kind);
                if (word_byte !== want_tok.chr)
                    report_mismatch("word_byte", word_byte, want_tok.chr);
                if (last_of_run !== want_tok.last)
                    report_mismatch("last_of_run", last_of_run, want_tok.last);
            end
        end
    end

    // Count down a long receiver hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_seen != hold_request)
        begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Pop at random, never during a hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task add_item(input logic [7:0] c, input logic eot);
        text_item_t it;
        it.ch  = c;
        it.eot = eot;
        pending_items.push_back(it);
        items_added++;
    endtask

    task add_string(input string s);
        for (int i = 0; i < s.len(); i++)
            add_item(s[i], 1'b0);
    endtask

    // Close the text with an end item or a zero byte
    task add_end();
        if ($urandom_range(1))
            add_item(8'($urandom_range(255)), 1'b1);
        else
            add_item(CH_NUL, 1'b0);
    endtask

    task add_word(input int len);
        string letters;
        letters = "abcdefghijklmnopqrstuvwxyzGHXYZ0123456789-_.%@!#*";
        for (int i = 0; i < len; i++)
            add_item(letters[$urandom_range(letters.len() - 1)], 1'b0);
    endtask

    task add_blanks();
        int n;
        logic [7:0] c;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: c = CH_SPACE;
                1: c = CH_TAB;
                2: c = CH_CR;
                default: c = CH_LF;
            endcase
            add_item(c, 1'b0);
        end
    endtask

    // Comment body: any nonzero byte, optionally avoiding line feed
    task add_comment_body(input bit no_lf);
        int n;
        logic [7:0] c;
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                c = ($urandom_range(1)) ? CH_STAR : CH_SLASH;
            else
                c = 8'($urandom_range(1, 255));
            if (no_lf && c == CH_LF)
                c = "q";
            add_item(c, 1'b0);
        end
    endtask

    task add_hex_color();
        string hexd;
        int n;
        hexd = "0123456789abcdefABCDEF";
        n = ($urandom_range(1)) ? 3 : 6;
        add_item(CH_HASH, 1'b0);
        for (int i = 0; i < n; i++)
            add_item(hexd[$urandom_range(hexd.len() - 1)], 1'b0);
    endtask

    // One well-formed piece of style text, ended most of the time
    task add_style_text();
        int pieces;
        int pick;
        logic [7:0] punct [4];
        punct = '{CH_LBRACE, CH_RBRACE, CH_COLON, CH_SEMI};
        pieces = $urandom_range(2, 10);
        for (int k = 0; k < pieces; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                add_word($urandom_range(1, 6));
            end
            else if (pick < 50)
            begin
                add_item(punct[$urandom_range(3)], 1'b0);
            end
            else if (pick < 60)
            begin
                add_blanks();
            end
            else if (pick < 68)
            begin
                add_hex_color();
            end
            else if (pick < 78)
            begin
                if ($urandom_range(1))
                    add_string("//");
                else
                    add_item(CH_HASH, 1'b0);
                add_comment_body(1'b1);
                add_item(CH_LF, 1'b0);
            end
            else if (pick < 88)
            begin
                add_string("/*");
                add_comment_body(1'b0);
                add_string("*/");
            end
            else
            begin
                // slash inside a word, then a word cut by a comment opener
                add_word($urandom_range(1, 3));
                add_item(CH_SLASH, 1'b0);
                add_word($urandom_range(1, 3));
                add_string(($urandom_range(1)) ? "//x\n" : "/*y*/");
            end
            if ($urandom_range(1))
                add_blanks();
        end
        if ($urandom_range(9) < 8)
            add_end();
    endtask

    // Random bytes of any value, zero included
    task add_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
            add_item(8'($urandom_range(255)), $urandom_range(15) == 0);
    endtask

    task wait_for_drain();
        while (pending_items.size() != 0 || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int target;
        @(posedge rst_n);
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase
            if (phase == 0)
            begin
                // empty text with an ignored byte of all ones
                add_item(8'hFF, 1'b1);
                // words, hex color, tokens, comments, slash before a zero byte
                add_string("k:#f;{/*/*/}#g\n//x\n/");
                add_item(CH_NUL, 1'b0);
                // hash right before the end starts a comment
                add_string(" #");
                add_item(CH_NUL, 1'b1);
                // word longer than the limit
                add_word(WORD_LIMIT + 5);
                add_item(CH_SEMI, 1'b0);
                add_end();
            end
            target = items_added + 32;
            while (items_added < target)
            begin
                if ($urandom_range(9) < 8)
                    add_style_text();
                else
                    add_noise();
            end
            add_end();
            // hold off the receiver while the sender keeps offering
            if (phase == 0 || phase == 2)
                hold_request++;
            wait_for_drain();
        end
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/style_text_tokenizer.sv
tb/testbench.sv
